/* rtl/escape_time_fractal_pixel_top_macros.svh */
// Assertion macros shared by the escape-time fractal RTL.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_TOP_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_TOP_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ETF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/etf_pkg.sv */
// Shared constants, types and fixed-point helpers of the escape-time fractal engine.
package etf_pkg;

	localparam int unsigned FRAC_BITS   = 28;
	localparam int unsigned VAL_W       = FRAC_BITS + 8;
	localparam int unsigned STEP_W      = FRAC_BITS + 7;
	localparam int unsigned SUM_W       = VAL_W + 3;
	localparam int unsigned MAX_WIDTH   = 1024;
	localparam int unsigned MAX_HEIGHT  = 1024;
	localparam int unsigned COORD_W     = 10;
	localparam int unsigned SIZE_W      = 11;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned FACTOR_W    = 8;
	localparam int unsigned SCALED_W    = COUNT_W + FACTOR_W;
	localparam int unsigned COLOR_W     = 32;
	localparam int unsigned COLOR_STEP  = 80000;
	localparam int unsigned CFG_DATA_W  = VAL_W;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// Split of a magnitude into a low word and a short high part for the multipliers.
	localparam int unsigned MUL_LO_W = 32;
	localparam int unsigned MUL_HI_W = VAL_W - MUL_LO_W;
	localparam int unsigned LL_W     = 2 * MUL_LO_W;
	localparam int unsigned LH_W     = MUL_LO_W + MUL_HI_W;
	localparam int unsigned HH_W     = 2 * MUL_HI_W;
	localparam int unsigned PROD_W   = 2 * VAL_W;
	localparam int unsigned RES_W    = PROD_W - FRAC_BITS;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	// 4.0 in the fixed-point format, one bit wider than a value
	localparam logic [VAL_W:0] ESCAPE_SQ =
		{{(VAL_W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

	localparam logic [COUNT_W-1:0]      RST_LIMIT  = COUNT_W'(50);
	localparam logic [STEP_W-1:0]       RST_STEP   = STEP_W'(894785);
	// -2.0 in the fixed-point format
	localparam logic signed [VAL_W-1:0] RST_ORIGIN =
		{{(VAL_W-FRAC_BITS-1){1'b1}}, {(FRAC_BITS+1){1'b0}}};
	localparam logic [FACTOR_W-1:0]     RST_FACTOR = FACTOR_W'(1);
	localparam logic [SIZE_W-1:0]       RST_WIDTH  = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0]       RST_HEIGHT = SIZE_W'(MAX_HEIGHT);

	typedef enum logic {
		MODE_SHIP    = 1'b0,
		MODE_TRICORN = 1'b1
	} fractal_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_LIMIT     = 3'd1,
		REG_STEP      = 3'd2,
		REG_ORIGIN_RE = 3'd3,
		REG_ORIGIN_IM = 3'd4,
		REG_FACTOR    = 3'd5,
		REG_WIDTH     = 3'd6,
		REG_HEIGHT    = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FOLD,
		ST_STEP,
		ST_SCALE,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		fractal_mode_t             mode;
		logic [COUNT_W-1:0]        limit;
		logic [STEP_W-1:0]         step;
		logic signed [VAL_W-1:0]   origin_re;
		logic signed [VAL_W-1:0]   origin_im;
		logic [FACTOR_W-1:0]       factor;
		logic [SIZE_W-1:0]         width;
		logic [SIZE_W-1:0]         height;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		logic signed [VAL_W-1:0] cr;
		logic signed [VAL_W-1:0] ci;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COUNT_W-1:0] count;
		logic               in_set;
		logic [COLOR_W-1:0] color;
	} res_t;

	typedef struct packed {
		logic [LL_W-1:0] ll;
		logic [LH_W-1:0] lh;
		logic [LH_W-1:0] hl;
		logic [HH_W-1:0] hh;
		logic            neg;
	} pp_t;

	function automatic logic [VAL_W-1:0] fx_mag(input logic signed [VAL_W-1:0] v);
		return v[VAL_W-1] ? -v : v;
	endfunction

	// Partial products of two magnitudes, each no wider than 32 x 32.
	function automatic pp_t fx_pp(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
			input logic neg);
		pp_t p;
		p.ll  = LL_W'(a[MUL_LO_W-1:0]) * LL_W'(b[MUL_LO_W-1:0]);
		p.lh  = LH_W'(a[MUL_LO_W-1:0]) * LH_W'(b[VAL_W-1:MUL_LO_W]);
		p.hl  = LH_W'(a[VAL_W-1:MUL_LO_W]) * LH_W'(b[MUL_LO_W-1:0]);
		p.hh  = HH_W'(a[VAL_W-1:MUL_LO_W]) * HH_W'(b[VAL_W-1:MUL_LO_W]);
		p.neg = neg;
		return p;
	endfunction

	// Sum the partial products, drop the fraction, apply the sign and saturate.
	function automatic logic signed [VAL_W-1:0] fx_fold(input pp_t p);
		logic [PROD_W-1:0] prod;
		logic [RES_W-1:0]  res;
		logic [VAL_W-1:0]  low;
		prod = PROD_W'(p.ll) + (PROD_W'(p.lh) << MUL_LO_W) + (PROD_W'(p.hl) << MUL_LO_W)
			+ (PROD_W'(p.hh) << LL_W);
		res = prod[PROD_W-1:FRAC_BITS];
		low = res[VAL_W-1:0];
		if (res[RES_W-1:VAL_W-1] != '0)
			return p.neg ? VAL_MIN : VAL_MAX;
		return p.neg ? -low : low;
	endfunction

	function automatic logic signed [VAL_W-1:0] fx_clamp(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){v[SUM_W-1]}})
			return v[SUM_W-1] ? VAL_MIN : VAL_MAX;
		return v[VAL_W-1:0];
	endfunction

endpackage

/* rtl/escape_time_fractal_pixel_top.sv */
// Top level of the burning-ship / tricorn escape-time pixel engine.

// Each transaction on the input side is one pixel coordinate. A coordinate at or beyond
// the configured image width or height is dropped and gives no result; every other one
// gives exactly one result, in input order, holding the coordinate, the iteration count,
// the inside flag and the colour count * 80000 * color_factor (mod 2^32, black inside).
// Arithmetic is signed Q8.28 fixed point with saturation. The front end checks the range
// and forms c = coordinate * pixel_step + origin in two pipeline stages, then places the
// item in a four-entry queue; the back end pulls one item at a time and iterates.
// Each iteration passes through ST_MUL (split 36-bit multiplies), ST_FOLD (fold and
// saturate) and ST_STEP (escape test and update of z), until the point escapes or the
// count reaches the limit; the reset limit is 50. The iteration loop sets the rate; the
// front end keeps taking coordinates until the queue and its stages fill, and a finished
// result waits in its output register while the next pixel iterates; that pixel's result
// is then held back until the earlier one is popped.
// Configuration registers are written through wr_en / wr_index / wr_data, and must be
// written only while no pixel is in flight. Reset is asynchronous and active low.
module escape_time_fractal_pixel_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [etf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [etf_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           push,
	output logic                           full,
	input  logic [etf_pkg::COORD_W-1:0]    coord_x,
	input  logic [etf_pkg::COORD_W-1:0]    coord_y,
	output logic                           empty,
	input  logic                           pop,
	output logic [etf_pkg::COORD_W-1:0]    out_x,
	output logic [etf_pkg::COORD_W-1:0]    out_y,
	output logic [etf_pkg::COUNT_W-1:0]    iter_count,
	output logic                           inside_set,
	output logic [etf_pkg::COLOR_W-1:0]    pixel_color
);
	import etf_pkg::*;

	cfg_t   cfg_q;
	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;
	item_t  q_wr_item;
	item_t  q_rd_item;
	res_t   res;

	// Configuration registers; every index of the port maps to one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_SHIP;
			cfg_q.limit     <= RST_LIMIT;
			cfg_q.step      <= RST_STEP;
			cfg_q.origin_re <= RST_ORIGIN;
			cfg_q.origin_im <= RST_ORIGIN;
			cfg_q.factor    <= RST_FACTOR;
			cfg_q.width     <= RST_WIDTH;
			cfg_q.height    <= RST_HEIGHT;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_MODE:      cfg_q.mode      <= fractal_mode_t'(wr_data[0]);
				REG_LIMIT:     cfg_q.limit     <= wr_data[COUNT_W-1:0];
				REG_STEP:      cfg_q.step      <= wr_data[STEP_W-1:0];
				REG_ORIGIN_RE: cfg_q.origin_re <= wr_data[VAL_W-1:0];
				REG_ORIGIN_IM: cfg_q.origin_im <= wr_data[VAL_W-1:0];
				REG_FACTOR:    cfg_q.factor    <= wr_data[FACTOR_W-1:0];
				REG_WIDTH:     cfg_q.width     <= wr_data[SIZE_W-1:0];
				REG_HEIGHT:    cfg_q.height    <= wr_data[SIZE_W-1:0];
			endcase
		end
	end

	// Range check and c computation; stalls only when the queue backs up.
	etf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_wr_item)
	);

	// Decouple the fast front end from the long-running iteration.
	etf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	// Iterate one pixel at a time and hold its result until popped.
	etf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_item  (q_rd_item),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign out_x       = res.x;
	assign out_y       = res.y;
	assign iter_count  = res.count;
	assign inside_set  = res.in_set;
	assign pixel_color = res.color;

endmodule

/* rtl/etf_queue.sv */
// Short item queue between the coordinate front end and the iteration back end.
`include "escape_time_fractal_pixel_top_macros.svh"

module etf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  etf_pkg::item_t wr_item,
	output logic           full,
	input  logic           rd_en,
	output etf_pkg::item_t rd_item,
	output logic           empty
);
	import etf_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	`ETF_ASSERT_IMPLY(a_queue_no_overflow, wr_en, !full, "item written into a full queue")
	`ETF_ASSERT_IMPLY(a_queue_no_underflow, rd_en, !empty, "item read from an empty queue")

endmodule

/* rtl/etf_front.sv */
// Front end: range check of each coordinate and forming of the point c.
`include "escape_time_fractal_pixel_top_macros.svh"

module etf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  etf_pkg::cfg_t                cfg,
	input  logic                         push,
	output logic                         full,
	input  logic [etf_pkg::COORD_W-1:0]  coord_x,
	input  logic [etf_pkg::COORD_W-1:0]  coord_y,
	input  logic                         q_full,
	output logic                         q_push,
	output etf_pkg::item_t               q_item
);
	import etf_pkg::*;

	localparam int unsigned PX_W  = COORD_W + STEP_W;
	localparam int unsigned CSUM_W = PX_W + 2;

	function automatic logic signed [VAL_W-1:0] clamp_c(input logic signed [CSUM_W-1:0] v);
		if (v[CSUM_W-1:VAL_W-1] != {(CSUM_W-VAL_W+1){v[CSUM_W-1]}})
			return v[CSUM_W-1] ? VAL_MIN : VAL_MAX;
		return v[VAL_W-1:0];
	endfunction

	logic                valid_s1;
	logic [COORD_W-1:0]  x_s1;
	logic [COORD_W-1:0]  y_s1;
	logic [PX_W-1:0]     px_s1;
	logic [PX_W-1:0]     py_s1;
	logic                valid_s2;
	item_t               item_s2;

	logic                in_range;
	logic                s1_ready;
	logic                s2_ready;
	logic signed [CSUM_W-1:0] sum_re;
	logic signed [CSUM_W-1:0] sum_im;

	assign in_range = (SIZE_W'(coord_x) < cfg.width) && (32'(coord_x) < MAX_WIDTH)
		&& (SIZE_W'(coord_y) < cfg.height) && (32'(coord_y) < MAX_HEIGHT);

	assign s2_ready = !valid_s2 || !q_full;
	assign s1_ready = !valid_s1 || s2_ready;
	assign full     = !s1_ready;
	assign q_push   = valid_s2 && !q_full;
	assign q_item   = item_s2;

	assign sum_re = $signed({2'b00, px_s1}) + CSUM_W'(cfg.origin_re);
	assign sum_im = $signed({2'b00, py_s1}) + CSUM_W'(cfg.origin_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			// drop coordinates outside the image here
			if (s1_ready)
				valid_s1 <= push && in_range;
			if (s2_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && push) begin
			x_s1  <= coord_x;
			y_s1  <= coord_y;
			px_s1 <= PX_W'(coord_x) * PX_W'(cfg.step);
			py_s1 <= PX_W'(coord_y) * PX_W'(cfg.step);
		end
		if (s2_ready && valid_s1) begin
			item_s2.x  <= x_s1;
			item_s2.y  <= y_s1;
			item_s2.cr <= clamp_c(sum_re);
			item_s2.ci <= clamp_c(sum_im);
		end
	end

	`ETF_ASSERT_NEXT(a_front_hold, valid_s2 && q_full, valid_s2 && $stable(item_s2), "stalled item lost")

endmodule

/* rtl/etf_back.sv */
// Back end: escape-time iteration, colour scaling and the result register.
`include "escape_time_fractal_pixel_top_macros.svh"

module etf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  etf_pkg::cfg_t  cfg,
	input  logic           q_empty,
	output logic           q_pop,
	input  etf_pkg::item_t q_item,
	output logic           empty,
	input  logic           pop,
	output etf_pkg::res_t  res
);
	import etf_pkg::*;

	back_state_t              state_q;
	back_state_t              state_d;
	item_t                    item_q;
	logic signed [VAL_W-1:0]  zr_q;
	logic signed [VAL_W-1:0]  zi_q;
	logic [COUNT_W-1:0]       n_q;
	pp_t                      pp_sr_q;
	pp_t                      pp_si_q;
	pp_t                      pp_cross_q;
	logic signed [VAL_W-1:0]  sr_q;
	logic signed [VAL_W-1:0]  si_q;
	logic signed [VAL_W-1:0]  cross_q;
	logic [SCALED_W-1:0]      scaled_q;
	logic                     inside_q;
	res_t                     res_q;
	logic                     res_v_q;

	logic                     emit;
	logic                     escape;
	logic [VAL_W:0]           mag_sq;
	logic [COUNT_W-1:0]       n_inc;
	logic [VAL_W-1:0]         mag_zr;
	logic [VAL_W-1:0]         mag_zi;
	logic                     cross_neg;
	logic signed [SUM_W-1:0]  two_cross;
	logic signed [VAL_W-1:0]  nr;
	logic signed [VAL_W-1:0]  ni;

	assign mag_zr    = fx_mag(zr_q);
	assign mag_zi    = fx_mag(zi_q);
	assign cross_neg = (cfg.mode == MODE_TRICORN) && (zr_q[VAL_W-1] != zi_q[VAL_W-1]);
	assign mag_sq    = {1'b0, sr_q} + {1'b0, si_q};
	assign escape    = (mag_sq >= ESCAPE_SQ);
	assign n_inc     = n_q + COUNT_W'(1);
	assign two_cross = SUM_W'(cross_q) <<< 1;
	assign nr        = fx_clamp(SUM_W'(sr_q) - SUM_W'(si_q) + SUM_W'(item_q.cr));
	assign ni        = (cfg.mode == MODE_TRICORN) ? fx_clamp(SUM_W'(item_q.ci) - two_cross)
		: fx_clamp(SUM_W'(item_q.ci) + two_cross);

	assign empty = !res_v_q;
	assign res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (cfg.limit == '0) ? ST_SCALE : ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_FOLD;
			ST_FOLD: state_d = ST_STEP;
			ST_STEP: begin
				if (escape || n_inc == cfg.limit)
					state_d = ST_SCALE;
				else
					state_d = ST_MUL;
			end
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!res_v_q || pop) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			zr_q   <= '0;
			zi_q   <= '0;
			n_q    <= '0;
		end
		if (state_q == ST_MUL) begin
			pp_sr_q    <= fx_pp(mag_zr, mag_zr, 1'b0);
			pp_si_q    <= fx_pp(mag_zi, mag_zi, 1'b0);
			pp_cross_q <= fx_pp(mag_zi, mag_zr, cross_neg);
		end
		if (state_q == ST_FOLD) begin
			sr_q    <= fx_fold(pp_sr_q);
			si_q    <= fx_fold(pp_si_q);
			cross_q <= fx_fold(pp_cross_q);
		end
		// advance z only when the point has not escaped
		if (state_q == ST_STEP && !escape) begin
			zr_q <= nr;
			zi_q <= ni;
			n_q  <= n_inc;
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= SCALED_W'(n_q) * SCALED_W'(cfg.factor);
			inside_q <= (n_q == cfg.limit);
		end
		if (emit) begin
			res_q.x      <= item_q.x;
			res_q.y      <= item_q.y;
			res_q.count  <= n_q;
			res_q.in_set <= inside_q;
			res_q.color  <= inside_q ? '0 : COLOR_W'(COLOR_W'(scaled_q) * COLOR_W'(COLOR_STEP));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else if (emit)
			res_v_q <= 1'b1;
		else if (pop)
			res_v_q <= 1'b0;
	end

	`ETF_ASSERT_IMPLY(a_back_below_limit, state_q == ST_STEP, n_q < cfg.limit, "iteration past limit")
	`ETF_ASSERT_IMPLY(a_back_no_clobber, emit, !res_v_q || pop, "waiting result overwritten")

endmodule
